>>> src/smrf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// smrf_pkg: shared types and constants of the square matrix rotate/flip block
// Opcodes, field widths, defaults and the controller/datapath command and
// status records.
// ============================================================================
package smrf_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 4;
  localparam int PIX_IO_W = 16;
  localparam int SIZE_W   = 5;

  // Defaults for the top level parameters and the size register.
  localparam int DEF_MAX_DIM     = 16;
  localparam int DEF_PIXEL_WIDTH = 16;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd3;

  // Request opcodes; codes six and seven are ignored.
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE      = 3'd0,
    OP_READ       = 3'd1,
    OP_ROT_CW     = 3'd2,
    OP_ROT_CCW    = 3'd3,
    OP_FLIP_HORIZ = 3'd4,
    OP_FLIP_VERT  = 3'd5
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic host_write;   // store the request pixel in the live bank
    logic host_read;    // issue a read of the live bank at the request address
    logic read_oor;     // load the hold register with an out-of-range answer
    logic capture;      // load the hold register with the memory read data
    logic load_out;     // move the hold register into the result register
    logic sweep_start;  // latch the transform kind and clear the sweep counters
    logic sweep_step;   // issue one source read and advance the sweep
    logic sweep_flip;   // swap the live and shadow banks
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;      // opcode of the pending request
    logic                in_matrix;   // request row and column are inside N
    logic                sweep_last;  // the last sweep position is being issued
  } dp_status_t;

endpackage

>>> src/smrf_if.sv
`timescale 1ns / 1ps
// ============================================================================
// smrf_if: request and result channel interfaces
// Valid/ready channels; a request is moved when valid and ready are both high
// at a rising clock edge.
// ============================================================================

// Request channel: opcode, pixel position and pixel value.
interface smrf_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [15:0] pixel_in;

  modport source (output valid, output opcode, output row_index, output col_index,
                  output pixel_in, input ready);
  modport sink (input valid, input opcode, input row_index, input col_index,
                input pixel_in, output ready);
endinterface

// Result channel: pixel value and out-of-range flag of a read.
interface smrf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_out;
  logic               out_of_range;

  modport source (output valid, output pixel_out, output out_of_range, input ready);
  modport sink (input valid, input pixel_out, input out_of_range, output ready);
endinterface

>>> src/smrf_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// smrf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module smrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/smrf_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// smrf_datapath: pixel banks, sweep address generator and result registers
// Two banks hold the live matrix and its shadow; a transform copies the live
// bank into the shadow through the source mapping, then the banks swap.
// ============================================================================
module smrf_datapath #(
  parameter int MAX_DIM     = 16,
  parameter int PIXEL_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [4:0]              cfg_wr_data,
  input  logic [2:0]              opcode,
  input  logic [3:0]              row_index,
  input  logic [3:0]              col_index,
  input  logic signed [15:0]      pixel_in,
  input  smrf_pkg::ctrl_cmd_t     cmd,
  output smrf_pkg::dp_status_t    status,
  output logic signed [15:0]      pixel_out,
  output logic                    out_of_range
);
  import smrf_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int CW    = IW + 6;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  // Size register and the clamped side length.
  logic [SIZE_W-1:0] matrix_size;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     n_side;
  logic [CW-1:0]     n_less1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      matrix_size <= cfg_wr_data;
    end
  end

  always_comb begin
    size_ext = CW'(matrix_size);
    if (size_ext == '0) begin
      n_side = CW'(1);
    end else if (size_ext > CW'(MAX_DIM)) begin
      n_side = CW'(MAX_DIM);
    end else begin
      n_side = size_ext;
    end
    n_less1 = n_side - CW'(1);
  end

  // Request position check and address.
  logic [CW-1:0] req_row_ext;
  logic [CW-1:0] req_col_ext;
  logic [AW-1:0] host_addr;

  assign req_row_ext = CW'(row_index);
  assign req_col_ext = CW'(col_index);
  assign host_addr   = {req_row_ext[IW-1:0], req_col_ext[IW-1:0]};

  assign status.opcode    = opcode;
  assign status.in_matrix = (req_row_ext < n_side) && (req_col_ext < n_side);

  // Sweep counters over every store position and the latched transform kind.
  op_t           kind;
  logic [IW-1:0] sw_row;
  logic [IW-1:0] sw_col;
  logic          sw_col_end;
  logic          sw_row_end;

  assign sw_col_end        = (sw_col == IW'(MAX_DIM - 1));
  assign sw_row_end        = (sw_row == IW'(MAX_DIM - 1));
  assign status.sweep_last = sw_col_end && sw_row_end;

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      kind   <= op_t'(opcode);
      sw_row <= '0;
      sw_col <= '0;
    end else if (cmd.sweep_step) begin
      if (sw_col_end) begin
        sw_col <= '0;
        sw_row <= sw_row + IW'(1);
      end else begin
        sw_col <= sw_col + IW'(1);
      end
    end
  end

  // Source position of the current sweep position; outside N it copies itself.
  logic [CW-1:0] sw_row_ext;
  logic [CW-1:0] sw_col_ext;
  logic [CW-1:0] src_row;
  logic [CW-1:0] src_col;
  logic [AW-1:0] src_addr;

  always_comb begin
    sw_row_ext = CW'(sw_row);
    sw_col_ext = CW'(sw_col);
    src_row    = sw_row_ext;
    src_col    = sw_col_ext;
    if ((sw_row_ext < n_side) && (sw_col_ext < n_side)) begin
      unique case (kind)
        OP_ROT_CW: begin
          src_row = n_less1 - sw_col_ext;
          src_col = sw_row_ext;
        end
        OP_ROT_CCW: begin
          src_row = sw_col_ext;
          src_col = n_less1 - sw_row_ext;
        end
        OP_FLIP_HORIZ: begin
          src_col = n_less1 - sw_col_ext;
        end
        OP_FLIP_VERT: begin
          src_row = n_less1 - sw_row_ext;
        end
        default: begin
          src_row = sw_row_ext;
          src_col = sw_col_ext;
        end
      endcase
    end
    src_addr = {src_row[IW-1:0], src_col[IW-1:0]};
  end

  // Shadow write pipeline: the read issued in one cycle is written the next.
  logic          wr_pend;
  logic [AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      wr_addr <= {sw_row, sw_col};
    end
  end

  // Live bank select.
  logic bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (cmd.sweep_flip) begin
      bank <= ~bank;
    end
  end

  // Bank ports.
  logic signed [31:0]      pix_wide_in;
  logic [PIXEL_WIDTH-1:0]  host_data;
  logic [AW-1:0]           rd_addr;
  logic [PIXEL_WIDTH-1:0]  rd_data0;
  logic [PIXEL_WIDTH-1:0]  rd_data1;
  logic [PIXEL_WIDTH-1:0]  rd_live;
  logic                    we0;
  logic                    we1;
  logic [AW-1:0]           wa0;
  logic [AW-1:0]           wa1;
  logic [PIXEL_WIDTH-1:0]  wd0;
  logic [PIXEL_WIDTH-1:0]  wd1;

  assign pix_wide_in = 32'(pixel_in);
  assign host_data   = pix_wide_in[PIXEL_WIDTH-1:0];
  assign rd_addr     = cmd.host_read ? host_addr : src_addr;
  assign rd_live     = bank ? rd_data1 : rd_data0;

  assign we0 = (cmd.host_write && !bank) || (wr_pend && bank);
  assign we1 = (cmd.host_write && bank) || (wr_pend && !bank);
  assign wa0 = cmd.host_write ? host_addr : wr_addr;
  assign wa1 = cmd.host_write ? host_addr : wr_addr;
  assign wd0 = cmd.host_write ? host_data : rd_live;
  assign wd1 = cmd.host_write ? host_data : rd_live;

  smrf_ram #(
    .WIDTH (PIXEL_WIDTH),
    .DEPTH (DEPTH)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (we0),
    .wr_addr (wa0),
    .wr_data (wd0),
    .rd_addr (rd_addr),
    .rd_data (rd_data0)
  );

  smrf_ram #(
    .WIDTH (PIXEL_WIDTH),
    .DEPTH (DEPTH)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (we1),
    .wr_addr (wa1),
    .wr_data (wd1),
    .rd_addr (rd_addr),
    .rd_data (rd_data1)
  );

  // Read data sign-extended from the pixel width.
  logic signed [PIXEL_WIDTH-1:0] rd_signed;
  logic signed [31:0]            rd_wide;

  assign rd_signed = rd_live;
  assign rd_wide   = 32'(rd_signed);

  // Hold register and result register.
  logic signed [15:0] hold_pix;
  logic               hold_oor;

  always_ff @(posedge clk) begin
    if (cmd.read_oor) begin
      hold_pix <= '0;
      hold_oor <= 1'b1;
    end else if (cmd.capture) begin
      hold_pix <= rd_wide[15:0];
      hold_oor <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_out    <= hold_pix;
      out_of_range <= hold_oor;
    end
  end

endmodule

>>> src/smrf_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// smrf_ctrl: request sequencer
// Accepts one request at a time, runs reads and whole-matrix sweeps, and
// owns the result valid flag.
// ============================================================================
module smrf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  smrf_pkg::dp_status_t status,
  output smrf_pkg::ctrl_cmd_t  cmd
);
  import smrf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RD_WAIT = 5'b00010,
    S_RESULT  = 5'b00100,
    S_SWEEP   = 5'b01000,
    S_DRAIN   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(status.opcode))
            OP_WRITE: begin
              cmd.host_write = status.in_matrix;
            end
            OP_READ: begin
              if (status.in_matrix) begin
                cmd.host_read = 1'b1;
                state_next    = S_RD_WAIT;
              end else begin
                cmd.read_oor = 1'b1;
                state_next   = S_RESULT;
              end
            end
            OP_ROT_CW, OP_ROT_CCW, OP_FLIP_HORIZ, OP_FLIP_VERT: begin
              cmd.sweep_start = 1'b1;
              state_next      = S_SWEEP;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.capture = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.sweep_flip = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/square_matrix_rotate_flip.sv
`timescale 1ns / 1ps
// ============================================================================
// square_matrix_rotate_flip: square pixel store with rotate and flip
// Writes and reads single pixels; rotates or flips the N by N matrix in place.
// ============================================================================
//
//  Channel    Dir   Handshake           Payload
//  request    in    valid/ready         opcode, row_index, col_index, pixel_in
//  result     out   valid/ready         pixel_out, out_of_range
//  cfg        in    cfg_wr_en           cfg_wr_data (matrix_size)
//
// A write is done when accepted. A read outside the matrix loads its result
// directly, one inside first waits for the bank read data; either then waits
// until the previous result is taken. A rotate or flip sweeps every store
// position: it reads one pixel of the live bank and writes one of the shadow bank per cycle.
// Synchronous reset returns the sequencer to idle and the size to 3; the
// pixel store is not cleared. A stalled result holds its value; writes and
// transforms are still taken, and a following read holds off new requests
// until the stalled result is taken.
//
module square_matrix_rotate_flip #(
  parameter int MAX_DIM     = smrf_pkg::DEF_MAX_DIM,
  parameter int PIXEL_WIDTH = smrf_pkg::DEF_PIXEL_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,
  smrf_in_if.sink    request,
  smrf_out_if.source result
);
  import smrf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       ctrl_in_ready;
  logic       ctrl_out_valid;

  assign request.ready = ctrl_in_ready;
  assign result.valid  = ctrl_out_valid;

  // Sequencer.
  smrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (ctrl_in_ready),
    .out_valid (ctrl_out_valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Pixel banks and address generation.
  smrf_datapath #(
    .MAX_DIM     (MAX_DIM),
    .PIXEL_WIDTH (PIXEL_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .opcode       (request.opcode),
    .row_index    (request.row_index),
    .col_index    (request.col_index),
    .pixel_in     (request.pixel_in),
    .cmd          (cmd),
    .status       (status),
    .pixel_out    (result.pixel_out),
    .out_of_range (result.out_of_range)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the square matrix rotate/flip block
// Sends write, read, rotate, flip and spare-opcode requests across many
// matrix sizes. A local image model predicts every read answer, and each
// result is checked field by field in order. Both channels idle and stall
// at random.
// ============================================================================
module tb;
  import smrf_pkg::*;

  localparam int DIM           = DEF_MAX_DIM;
  localparam int SWEEP_CYCLES  = DIM * DIM + 2;
  localparam int SETTLE_CYCLES = SWEEP_CYCLES + 8;
  localparam int QUIET_LIMIT   = 20 * SWEEP_CYCLES;

  // Opcodes that the block has to ignore.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [INDEX_W-1:0]         row;
    logic [INDEX_W-1:0]         col;
    logic signed [PIX_IO_W-1:0] pixel;
  } pixel_req_t;

  typedef struct packed {
    logic signed [PIX_IO_W-1:0] pixel;
    logic                       oor;
  } read_answer_t;

  // One store entry; the written flag keeps reads away from unwritten pixels.
  typedef struct packed {
    logic                       written;
    logic signed [PIX_IO_W-1:0] value;
  } store_word_t;

  typedef store_word_t [DIM*DIM-1:0] image_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [SIZE_W-1:0]  cfg_wr_data;

  smrf_in_if  request_ch();
  smrf_out_if result_ch();

  square_matrix_rotate_flip u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .request     (request_ch),
    .result      (result_ch)
  );

  // Request generation state, advanced as requests are queued.
  pixel_req_t pending[$];
  image_t     gen_image;
  int         gen_n;
  int         queued_count = 0;

  // Image model, advanced as requests are accepted.
  image_t       live_image;
  int           live_n;
  read_answer_t read_answers[$];
  int           accepted_count = 0;
  int           fail_count     = 0;
  int           quiet_cycles   = 0;

  // Idling control.
  logic calm       = 1'b0;
  int   calm_timer = 0;
  int   send_gap   = 0;
  int   stall_left = 0;

  always #5 clk = ~clk;

  // Side length in use: the size register clamped to 1..DIM.
  function automatic int side_of(logic [SIZE_W-1:0] size_val);
    if (size_val < 1) return 1;
    if (size_val > DIM) return DIM;
    return int'(size_val);
  endfunction

  // Whole-matrix rotate or flip of the n by n corner; the rest is untouched.
  function automatic image_t transform_image(image_t src, logic [OPCODE_W-1:0] kind, int n);
    image_t dst;
    int     sr;
    int     sc;
    dst = src;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        case (kind)
          OP_ROT_CW: begin
            sr = n - 1 - c;
            sc = r;
          end
          OP_ROT_CCW: begin
            sr = c;
            sc = n - 1 - r;
          end
          OP_FLIP_HORIZ: begin
            sr = r;
            sc = n - 1 - c;
          end
          default: begin
            sr = n - 1 - r;
            sc = c;
          end
        endcase
        dst[r*DIM+c] = src[sr*DIM+sc];
      end
    end
    return dst;
  endfunction

  function automatic logic is_transform(logic [OPCODE_W-1:0] op);
    return (op == OP_ROT_CW) || (op == OP_ROT_CCW) ||
           (op == OP_FLIP_HORIZ) || (op == OP_FLIP_VERT);
  endfunction

  // Mostly no gap, some short ones and a few long ones; none in calm stretches.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Queue one request and track which pixels will hold written data.
  task automatic queue_request(logic [OPCODE_W-1:0] op, int r, int c,
                               logic signed [PIX_IO_W-1:0] pix);
    pixel_req_t req;
    int         idx;
    req.opcode = op;
    req.row    = INDEX_W'(r);
    req.col    = INDEX_W'(c);
    req.pixel  = pix;
    pending.push_back(req);
    queued_count++;
    idx = r * DIM + c;
    if (op == OP_WRITE && r < gen_n && c < gen_n) begin
      gen_image[idx].written = 1'b1;
      gen_image[idx].value   = pix;
    end else if (is_transform(op)) begin
      gen_image = transform_image(gen_image, op, gen_n);
    end
  endtask

  // One random request. Reads inside the matrix only target written pixels.
  task automatic queue_random(output bit counted);
    int roll;
    int r;
    int c;
    int idx;
    int spots[$];
    counted = 1'b1;
    roll = $urandom_range(0, 99);
    r = $urandom_range(0, gen_n - 1);
    c = $urandom_range(0, gen_n - 1);
    if (roll < 38) begin
      queue_request(OP_WRITE, r, c, PIX_IO_W'($urandom()));
    end else if (roll < 73) begin
      if (gen_n < DIM && $urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, DIM - 1);
        c = $urandom_range(0, DIM - 1);
        if (r < gen_n && c < gen_n) begin
          if ($urandom_range(0, 1) == 1) r = $urandom_range(gen_n, DIM - 1);
          else c = $urandom_range(gen_n, DIM - 1);
        end
        queue_request(OP_READ, r, c, PIX_IO_W'($urandom()));
      end else begin
        for (int rr = 0; rr < gen_n; rr++)
          for (int cc = 0; cc < gen_n; cc++)
            if (gen_image[rr*DIM+cc].written) spots.push_back(rr * DIM + cc);
        if (spots.size() == 0) begin
          queue_request(OP_WRITE, r, c, PIX_IO_W'($urandom()));
        end else begin
          idx = spots[$urandom_range(0, spots.size() - 1)];
          queue_request(OP_READ, idx / DIM, idx % DIM, PIX_IO_W'($urandom()));
        end
      end
    end else if (roll < 88) begin
      queue_request(OPCODE_W'($urandom_range(OP_ROT_CW, OP_FLIP_VERT)),
                    $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                    PIX_IO_W'($urandom()));
    end else if (roll < 94) begin
      // Write that lands outside the matrix whenever the size allows it.
      if (gen_n < DIM) begin
        if ($urandom_range(0, 1) == 1) r = $urandom_range(gen_n, DIM - 1);
        else c = $urandom_range(gen_n, DIM - 1);
      end
      queue_request(OP_WRITE, r, c, PIX_IO_W'($urandom()));
    end else begin
      counted = 1'b0;
      queue_request(OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                    $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                    PIX_IO_W'($urandom()));
    end
  endtask

  // Wait until every request is taken and every read answered, then let a
  // transform sweep that produces no result run out.
  task automatic drain();
    while (accepted_count != queued_count || read_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite the size register while the block is idle.
  task automatic set_size(logic [SIZE_W-1:0] size_val);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_n = side_of(size_val);
    @(negedge clk);
  endtask

  task automatic run_phase(logic [SIZE_W-1:0] size_val, int count);
    int done;
    bit counted;
    set_size(size_val);
    done = 0;
    while (done < count) begin
      queue_random(counted);
      if (counted) done++;
    end
  endtask

  // Stimulus sequence.
  initial begin
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    request_ch.valid       = 1'b0;
    request_ch.opcode      = '0;
    request_ch.row_index   = '0;
    request_ch.col_index   = '0;
    request_ch.pixel_in    = '0;
    result_ch.ready        = 1'b0;
    gen_image              = '0;
    live_image             = '0;
    gen_n                  = side_of(SIZE_RESET);
    live_n                 = side_of(SIZE_RESET);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset size of three: fill, transform, read back.
    queue_request(OP_WRITE, 0, 0, 16'sh8000);
    queue_request(OP_WRITE, 0, 1, 16'sh0001);
    queue_request(OP_WRITE, 0, 2, 16'sh7FFF);
    queue_request(OP_WRITE, 1, 0, 16'sh0002);
    queue_request(OP_WRITE, 1, 1, 16'sh5A5A);
    queue_request(OP_WRITE, 1, 2, 16'shA5A5);
    queue_request(OP_WRITE, 2, 0, 16'shFFFF);
    queue_request(OP_WRITE, 2, 1, 16'sh0004);
    queue_request(OP_WRITE, 2, 2, 16'sh0000);
    queue_request(OP_READ, 0, 0, 16'sh0000);
    queue_request(OP_ROT_CW, 0, 0, 16'sh0000);
    queue_request(OP_READ, 0, 0, 16'shFFFF);
    queue_request(OP_ROT_CCW, 15, 15, 16'sh7FFF);
    queue_request(OP_FLIP_HORIZ, 0, 0, 16'sh0000);
    queue_request(OP_READ, 0, 2, 16'sh0000);
    queue_request(OP_FLIP_VERT, 0, 0, 16'sh0000);
    queue_request(OP_READ, 2, 2, 16'sh0000);
    queue_request(OP_READ, 15, 15, 16'sh0000);
    queue_request(OP_READ, 0, 3, 16'sh0000);
    queue_request(OP_WRITE, 3, 3, 16'sh1234);
    queue_request(OP_SPARE_LO, 1, 1, 16'sh7FFF);
    queue_request(OP_SPARE_HI, 2, 2, 16'sh8000);
    queue_request(OP_READ, 1, 1, 16'sh0000);

    // Random phases over a spread of sizes, extremes and clamped values too.
    run_phase(5'd16, 260);
    run_phase(5'd1, 80);
    run_phase(5'd0, 60);
    run_phase(5'd31, 200);
    run_phase(5'd17, 200);
    run_phase(5'd2, 100);
    run_phase(5'd5, 150);
    run_phase(5'd8, 150);
    run_phase(SIZE_W'($urandom_range(1, 31)), 125);
    run_phase(SIZE_W'($urandom_range(1, 31)), 125);

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Alternate stretches of random idling with stretches of none.
  always @(posedge clk) begin
    calm_timer <= calm_timer + 1;
    if (calm_timer % 200 == 199) calm <= ($urandom_range(0, 3) == 0);
  end

  // Request driver: presents queued requests with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      request_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!request_ch.valid || request_ch.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        request_ch.valid <= 1'b0;
      end else if (pending.size() > 0) begin
        pixel_req_t req;
        req = pending.pop_front();
        request_ch.valid     <= 1'b1;
        request_ch.opcode    <= req.opcode;
        request_ch.row_index <= req.row;
        request_ch.col_index <= req.col;
        request_ch.pixel_in  <= req.pixel;
        send_gap = pick_gap();
      end else begin
        request_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: stalls after some results and at random idle moments.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if ((result_ch.valid && result_ch.ready) || $urandom_range(0, 15) == 0) begin
      stall_left = pick_gap();
      result_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: advances the image model on each request and checks each result.
  always @(posedge clk) begin
    if (!rst) begin : monitor
      logic         moved;
      logic         in_matrix;
      int           r;
      int           c;
      read_answer_t ans;
      moved = 1'b0;
      if (cfg_wr_en) live_n = side_of(cfg_wr_data);

      if (request_ch.valid && request_ch.ready) begin
        moved = 1'b1;
        accepted_count++;
        r = int'(request_ch.row_index);
        c = int'(request_ch.col_index);
        in_matrix = (r < live_n) && (c < live_n);
        if (request_ch.opcode == OP_WRITE) begin
          if (in_matrix) begin
            live_image[r*DIM+c].written = 1'b1;
            live_image[r*DIM+c].value   = request_ch.pixel_in;
          end
        end else if (request_ch.opcode == OP_READ) begin
          ans.oor   = !in_matrix;
          ans.pixel = in_matrix ? live_image[r*DIM+c].value : '0;
          read_answers.push_back(ans);
        end else if (is_transform(request_ch.opcode)) begin
          live_image = transform_image(live_image, request_ch.opcode, live_n);
        end
      end

      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        if (read_answers.size() == 0) begin
          $error("result with no read waiting: pixel_out %0d out_of_range %0b",
                 result_ch.pixel_out, result_ch.out_of_range);
          fail_count++;
        end else begin
          ans = read_answers.pop_front();
          if (result_ch.pixel_out !== ans.pixel) begin
            $error("pixel_out: expected %0d, got %0d", ans.pixel, result_ch.pixel_out);
            fail_count++;
          end
          if (result_ch.out_of_range !== ans.oor) begin
            $error("out_of_range: expected %0b, got %0b", ans.oor, result_ch.out_of_range);
            fail_count++;
          end
        end
      end

      // Watchdog on cycles in which neither channel moves anything.
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
